>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ASSERT_CLKED(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLKED(label, (ante) |=> (cons), msg)

`endif

>>> design/gpshd_pkg.sv
package gpshd_pkg;

    // Field widths of one fix and of one result.
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int HEAD_W = 17;
    localparam int OCT_W  = 3;
    localparam int REL_W  = 14;

    // Bus widths: the fields are packed from bit 0 and padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // Differences and magnitudes.
    localparam int DLAT_W = LAT_W + 1;
    localparam int DLON_W = LON_W + 1;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 23;
    localparam int STEP_W       = 5;
    localparam int CX_W         = 36;
    localparam int Z_W          = 24;
    localparam int PHI_W        = 15;

    // Angles in 1/256 degree.
    localparam int FULL_CIRCLE    = 92160;
    localparam int HALF_CIRCLE    = 46080;
    localparam int QUARTER_CIRCLE = 23040;
    localparam int OCTANT_SPAN    = 11520;
    localparam int OCTANTS        = 8;

    // Main sequencer.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_START,
        S_WAIT,
        S_OCT,
        S_EMIT
    } t_seq_state;

    // CORDIC unit sequencer.
    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ROUND,
        C_DONE
    } t_cordic_state;

    // Status of the CORDIC unit as seen by the main sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // atan(2^-i) in 1/65536 degree, rounded.
    function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] step);
        logic signed [Z_W-1:0] t;
        unique case (step)
            5'd0:    t = 24'sd2949120;
            5'd1:    t = 24'sd1740967;
            5'd2:    t = 24'sd919879;
            5'd3:    t = 24'sd466945;
            5'd4:    t = 24'sd234379;
            5'd5:    t = 24'sd117304;
            5'd6:    t = 24'sd58666;
            5'd7:    t = 24'sd29335;
            5'd8:    t = 24'sd14668;
            5'd9:    t = 24'sd7334;
            5'd10:   t = 24'sd3667;
            5'd11:   t = 24'sd1833;
            5'd12:   t = 24'sd917;
            5'd13:   t = 24'sd458;
            5'd14:   t = 24'sd229;
            5'd15:   t = 24'sd115;
            5'd16:   t = 24'sd57;
            5'd17:   t = 24'sd29;
            5'd18:   t = 24'sd14;
            5'd19:   t = 24'sd7;
            5'd20:   t = 24'sd4;
            5'd21:   t = 24'sd2;
            5'd22:   t = 24'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Lower edge of an octant in 1/256 degree.
    function automatic logic [HEAD_W-1:0] octant_base(input logic [OCT_W-1:0] oct);
        return HEAD_W'(oct) * HEAD_W'(OCTANT_SPAN);
    endfunction

endpackage

>>> design/gpshd_ram.sv
module gpshd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/gpshd_cordic.sv
module gpshd_cordic import gpshd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DLON_W-1:0]  i_x_mag,
    input  logic [DLAT_W-1:0]  i_y_mag,
    output logic [PHI_W-1:0]   o_phi,
    output t_cordic_stat       o_stat
);

    t_cordic_state             r_state, n_state;
    logic signed [CX_W-1:0]    r_x, r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [STEP_W-1:0]         r_step;
    logic                      r_x_zero, r_y_zero;
    logic [PHI_W-1:0]          r_phi;

    logic signed [CX_W-1:0]    x_sh, y_sh;
    logic signed [Z_W-1:0]     t_step, z_rnd;
    logic [PHI_W-1:0]          phi_clamped;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_start) n_state = C_RUN;
            C_RUN:   if (r_step == STEP_W'(CORDIC_STEPS - 1)) n_state = C_ROUND;
            C_ROUND: n_state = C_DONE;
            C_DONE:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // Status outputs.
    always_comb begin
        o_stat.busy = (r_state != C_IDLE);
        o_stat.done = (r_state == C_DONE);
    end

    // The shared shift-and-add step and the final rounding.
    always_comb begin
        x_sh   = r_x >>> r_step;
        y_sh   = r_y >>> r_step;
        t_step = atan_step(r_step);
        z_rnd  = (r_z + Z_W'(128)) >>> 8;
        priority if (z_rnd[Z_W-1]) begin
            phi_clamped = '0;
        end else if (z_rnd > Z_W'(QUARTER_CIRCLE)) begin
            phi_clamped = PHI_W'(QUARTER_CIRCLE);
        end else begin
            phi_clamped = z_rnd[PHI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers: load, rotate once a cycle, then round.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_x      <= CX_W'(i_x_mag);
                    r_y      <= CX_W'(i_y_mag);
                    r_z      <= '0;
                    r_step   <= '0;
                    r_x_zero <= (i_x_mag == '0);
                    r_y_zero <= (i_y_mag == '0);
                end
            end
            C_RUN: begin
                if (!r_y[CX_W-1]) begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + t_step;
                end else begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - t_step;
                end
                r_step <= r_step + STEP_W'(1);
            end
            C_ROUND: begin
                priority if (r_y_zero) begin
                    r_phi <= '0;
                end else if (r_x_zero) begin
                    r_phi <= PHI_W'(QUARTER_CIRCLE);
                end else begin
                    r_phi <= phi_clamped;
                end
            end
            C_DONE: begin
                r_phi <= r_phi;
            end
            default: begin
                r_phi <= r_phi;
            end
        endcase
    end

    assign o_phi = r_phi;

endmodule

>>> design/gps_heading_from_position_history.sv
// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         latitude[30:0], longitude[62:31], zero pad to 64
// m_axis    out        heading[16:0], octant[19:17], relative_angle[33:20], zero pad to 40
//
// A fix is taken only in the idle state, once the result of the last fix is registered
// for output. The fix then goes through the history read and the difference, the CORDIC
// load, the 23 CORDIC steps on one shared shift-and-add unit, rounding and hand-over,
// and last the octant and output stages.
// Reset is synchronous and active low; the history is not cleared and needs no clear pass.
// A result waiting on m_axis does not block the next transfer on s_axis; the block
// stalls in its last cycle only if the earlier result is still untaken.
`include "assert_macros.svh"

module gps_heading_from_position_history import gpshd_pkg::*; #(
    parameter int HISTORY_DEPTH = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // latitude, longitude
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // heading, octant, relative_angle
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int FIX_W  = LAT_W + LON_W;

    t_seq_state              r_state, n_state;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_full;
    logic signed [LAT_W-1:0] r_lat;
    logic signed [LON_W-1:0] r_lon;
    logic signed [DLAT_W-1:0] r_dlat;
    logic signed [DLON_W-1:0] r_dlon;
    logic [HEAD_W-1:0]       r_heading;
    logic [OCT_W-1:0]        r_octant;
    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;

    logic                    in_xfer;
    logic                    slot_last;
    logic                    rd_en, cordic_start, out_load;
    logic [FIX_W-1:0]        rd_data;
    logic [SLOT_W-1:0]       rd_addr;
    logic signed [LAT_W-1:0] ref_lat;
    logic signed [LON_W-1:0] ref_lon;
    logic [DLON_W-1:0]       x_mag;
    logic [DLAT_W-1:0]       y_mag;
    logic [PHI_W-1:0]        phi;
    t_cordic_stat            cordic_stat;
    logic [HEAD_W-1:0]       heading_raw;
    logic [OCT_W-1:0]        octant_calc;
    logic [HEAD_W-1:0]       oct_base;
    logic [HEAD_W-1:0]       rel_wide;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign slot_last = (r_slot == SLOT_W'(HISTORY_DEPTH - 1));

    // History of fixes; the oldest entry is the next one to be written once full.
    assign rd_addr = r_full ? r_slot : '0;

    gpshd_ram #(
        .WIDTH (FIX_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_addr (r_slot),
        .i_wr_data (s_axis_tdata[FIX_W-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign ref_lat = rd_data[LAT_W-1:0];
    assign ref_lon = rd_data[FIX_W-1:LAT_W];

    // Fold the difference vector into the first quadrant.
    assign x_mag = r_dlon[DLON_W-1] ? DLON_W'(-r_dlon) : DLON_W'(r_dlon);
    assign y_mag = r_dlat[DLAT_W-1] ? DLAT_W'(-r_dlat) : DLAT_W'(r_dlat);

    gpshd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x_mag (x_mag),
        .i_y_mag (y_mag),
        .o_phi   (phi),
        .o_stat  (cordic_stat)
    );

    // Next state of the main sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_READ;
            S_READ:  n_state = S_DIFF;
            S_DIFF:  n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (cordic_stat.done) n_state = S_OCT;
            S_OCT:   n_state = S_EMIT;
            S_EMIT:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        rd_en         = (r_state == S_READ);
        cordic_start  = (r_state == S_START);
        out_load      = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);
    end

    // Unfold the quadrant angle into 0..360 degrees.
    always_comb begin
        unique case ({r_dlat[DLAT_W-1], r_dlon[DLON_W-1]})
            2'b00:   heading_raw = HEAD_W'(phi);
            2'b01:   heading_raw = HEAD_W'(HALF_CIRCLE) - HEAD_W'(phi);
            2'b11:   heading_raw = HEAD_W'(HALF_CIRCLE) + HEAD_W'(phi);
            default: heading_raw = (phi == '0) ? '0 : HEAD_W'(FULL_CIRCLE) - HEAD_W'(phi);
        endcase
    end

    // Octant: how many octant edges the heading lies strictly above.
    always_comb begin
        octant_calc = '0;
        for (int k = 1; k < OCTANTS; k++) begin
            if (r_heading > HEAD_W'(OCTANT_SPAN * k)) begin
                octant_calc = octant_calc + OCT_W'(1);
            end
        end
    end

    // Angle from the octant's reference axis.
    always_comb begin
        oct_base = octant_base(r_octant);
        if (!r_octant[0]) begin
            rel_wide = r_heading - oct_base;
        end else begin
            rel_wide = oct_base + HEAD_W'(OCTANT_SPAN) - r_heading;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                if (slot_last) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lat <= s_axis_tdata[LAT_W-1:0];
            r_lon <= s_axis_tdata[FIX_W-1:LAT_W];
        end
        if (r_state == S_DIFF) begin
            r_dlat <= DLAT_W'(r_lat) - DLAT_W'(ref_lat);
            r_dlon <= DLON_W'(r_lon) - DLON_W'(ref_lon);
        end
        if (r_state == S_WAIT && cordic_stat.done) begin
            r_heading <= heading_raw;
        end
        if (r_state == S_OCT) begin
            r_octant <= octant_calc;
        end
        if (out_load) begin
            r_out_data <= {(M_TDATA_W - HEAD_W - OCT_W - REL_W)'(0),
                           rel_wide[REL_W-1:0], r_octant, r_heading};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks on the sequencer and the history ring.
    `ASSERT_NEXT(a_one_fix_at_a_time, in_xfer, !s_axis_tready, "transfer taken while busy")
    `ASSERT_NEXT(a_full_sticky, r_full, r_full, "history full flag dropped")
    `ASSERT_NEXT(a_ring_wrap, in_xfer && slot_last, r_full && r_slot == '0, "ring did not wrap")
    `ASSERT_CLKED(a_cordic_done_waited, cordic_stat.done |-> r_state == S_WAIT, "CORDIC result not awaited")
    `ASSERT_CLKED(a_cordic_start_idle, cordic_start |-> !cordic_stat.busy, "CORDIC started while busy")

endmodule

>>> tb/tb_gps_heading_from_position_history.sv
`timescale 1ns / 100ps

module tb_gps_heading_from_position_history;
    import gpshd_pkg::*;

    localparam int HISTORY_DEPTH  = 50;
    localparam int MAX_REPORTS    = 10;
    localparam int RESULT_LATENCY = 30;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int TRACK_FIXES    = 400;

    // atan(2^-i) in 1/65536 degree, one entry per rotation step.
    localparam longint ARC_LUT [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [OCT_W-1:0]  octant;
        logic [REL_W-1:0]  rel_angle;
    } t_bearing;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // latitude, longitude
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // heading, octant, relative_angle

    // Shadow copy of the fix history kept by the predictor.
    longint   fix_lat [HISTORY_DEPTH];
    longint   fix_lon [HISTORY_DEPTH];
    int       ring_slot;
    bit       ring_full;

    t_bearing expected_bearings [$];
    int       mismatch_count;
    bit       tx_idle_en;
    bit       rx_idle_en;
    int       hold_off_cycles;

    gps_heading_from_position_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint random_offset(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // First-quadrant angle of (x, y) by vectoring rotations, in 1/256 degree.
    function automatic longint quadrant_phi(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        if (y == 0) return 0;
        if (x == 0) return QUARTER_CIRCLE;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ARC_LUT[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ARC_LUT[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z < 0) z = 0;
        if (z > QUARTER_CIRCLE) z = QUARTER_CIRCLE;
        return z;
    endfunction

    // Stores the new fix and works out the bearing from the reference fix to it.
    function automatic t_bearing predict_bearing(input logic [LAT_W-1:0] lat_bits,
                                                 input logic [LON_W-1:0] lon_bits);
        longint   lat;
        longint   lon;
        longint   dlat;
        longint   dlon;
        longint   phi;
        longint   heading;
        longint   oct;
        longint   rel;
        int       ref_slot;
        t_bearing b;
        lat = $signed(lat_bits);
        lon = $signed(lon_bits);
        fix_lat[ring_slot] = lat;
        fix_lon[ring_slot] = lon;
        ring_slot++;
        if (ring_slot >= HISTORY_DEPTH) begin
            ring_slot = 0;
            ring_full = 1'b1;
        end
        // Entry 0 is the reference until the ring has wrapped, then the oldest fix.
        ref_slot = ring_full ? ring_slot : 0;
        dlat = lat - fix_lat[ref_slot];
        dlon = lon - fix_lon[ref_slot];
        phi  = quadrant_phi(dlon < 0 ? -dlon : dlon, dlat < 0 ? -dlat : dlat);
        if (dlat >= 0)
            heading = (dlon >= 0) ? phi : HALF_CIRCLE - phi;
        else
            heading = (dlon < 0) ? HALF_CIRCLE + phi : FULL_CIRCLE - phi;
        if (heading >= FULL_CIRCLE) heading -= FULL_CIRCLE;
        // A heading on an octant edge belongs to the lower octant.
        oct = (heading == 0) ? 0 : (heading - 1) / OCTANT_SPAN;
        if (oct % 2 == 0)
            rel = heading - OCTANT_SPAN * oct;
        else
            rel = OCTANT_SPAN * (oct + 1) - heading;
        b.heading   = HEAD_W'(heading);
        b.octant    = OCT_W'(oct);
        b.rel_angle = REL_W'(rel);
        return b;
    endfunction

    // Slot that the next fix will be compared with.
    function automatic int next_reference_slot();
        if (ring_full || ring_slot + 1 >= HISTORY_DEPTH)
            return (ring_slot + 1) % HISTORY_DEPTH;
        return 0;
    endfunction

    // Offers one fix, waits for its transfer and withdraws it, then idles if enabled.
    task automatic send_fix(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
        int gap;
        @(negedge i_clk);
        s_axis_tdata  = {{(S_TDATA_W - LAT_W - LON_W){1'b0}}, lon, lat};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_bearings.push_back(predict_bearing(lat, lon));
        gap = tx_idle_en ? random_gap() : 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    // Sends a fix placed at a chosen displacement from the fix it will be compared with.
    task automatic send_offset(input longint dlat, input longint dlon);
        int               r;
        logic [LAT_W-1:0] lat_bits;
        logic [LON_W-1:0] lon_bits;
        r        = next_reference_slot();
        lat_bits = LAT_W'(fix_lat[r] + dlat);
        lon_bits = LON_W'(fix_lon[r] + dlon);
        send_fix(lat_bits, lon_bits);
    endtask

    task automatic drain_results();
        while (expected_bearings.size() != 0) @(posedge i_clk);
    endtask

    // The first fix is compared with itself; a repeated position gives a zero bearing.
    task automatic test_same_position();
        send_fix('0, '0);
        send_offset(0, 0);
    endtask

    // Axes, exact diagonals and the middle of every octant.
    task automatic test_compass_directions();
        longint d_lat [16] = '{0, 1, 1000, 1, 0, -1, -1000, -1,
                               300, 1000, 1000, 300, -300, -1000, -1000, -300};
        longint d_lon [16] = '{1000, 1, 0, -1, -1000, -1, 0, 1,
                               1000, 300, -300, -1000, -1000, -300, 300, 1000};
        for (int i = 0; i < 16; i++)
            send_offset(d_lat[i], d_lon[i]);
    endtask

    // Full-scale bit patterns and the limits of the legal coordinate range.
    task automatic test_field_extremes();
        send_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF);
        send_fix(31'h4000_0000, 32'h8000_0000);
        send_fix(31'h3FFF_FFFF, 32'h8000_0000);
        send_fix(31'h4000_0000, 32'h7FFF_FFFF);
        send_fix(31'sd900000000, 32'sd1800000000);
        send_fix(-31'sd900000000, -32'sd1800000000);
        send_fix('1, '1);
        send_fix('0, '0);
    endtask

    // The sender stops until every outstanding result has been taken.
    task automatic test_sender_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (6) send_offset(random_offset(5000), random_offset(5000));
        drain_results();
        repeat (6) send_offset(random_offset(5000), random_offset(5000));
    endtask

    // The receiver holds off while fixes keep coming, so the input side stalls.
    task automatic test_receiver_hold();
        tx_idle_en      = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (12) send_offset(random_offset(100000), random_offset(100000));
        drain_results();
    endtask

    // A long random track, wrapping the history ring many times.
    task automatic test_random_track();
        int     kind;
        longint m;
        longint span;
        for (int n = 0; n < TRACK_FIXES; n++) begin
            if (n % 75 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                send_fix(LAT_W'($urandom()), LON_W'($urandom()));
            end else if (kind < 55) begin
                span = ($urandom_range(0, 1) != 0) ? 1000 : 10000000;
                if ($urandom_range(0, 9) == 0)
                    send_offset(0, random_offset(span));
                else if ($urandom_range(0, 9) == 0)
                    send_offset(random_offset(span), 0);
                else
                    send_offset(random_offset(span), random_offset(span));
            end else if (kind < 70) begin
                // Exact diagonals land on the octant edges.
                m = $urandom_range(1, 5000000);
                send_offset(($urandom_range(0, 1) != 0) ? m : -m,
                            ($urandom_range(0, 1) != 0) ? m : -m);
            end else begin
                send_fix(LAT_W'(longint'($urandom_range(0, 1800000000)) - 900000000),
                         LON_W'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000));
            end
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_off_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (rx_idle_en && $urandom_range(0, 99) < 20)
                    stall_left = random_gap();
            end
        end
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // Each result transfer is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_bearing want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bearings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding, tdata %h",
                             $time, m_axis_tdata);
            end else begin
                want = expected_bearings.pop_front();
                if (m_axis_tdata[HEAD_W-1:0] !== want.heading)
                    note_mismatch("heading", want.heading, m_axis_tdata[HEAD_W-1:0]);
                if (m_axis_tdata[HEAD_W+OCT_W-1:HEAD_W] !== want.octant)
                    note_mismatch("octant", want.octant,
                                  m_axis_tdata[HEAD_W+OCT_W-1:HEAD_W]);
                if (m_axis_tdata[HEAD_W+OCT_W+REL_W-1:HEAD_W+OCT_W] !== want.rel_angle)
                    note_mismatch("relative angle", want.rel_angle,
                                  m_axis_tdata[HEAD_W+OCT_W+REL_W-1:HEAD_W+OCT_W]);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        tx_idle_en      = 1'b0;
        rx_idle_en      = 1'b0;
        hold_off_cycles = 0;
        mismatch_count  = 0;
        ring_slot       = 0;
        ring_full       = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            fix_lat[i] = 0;
            fix_lon[i] = 0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_same_position();
        test_compass_directions();
        test_field_extremes();
        test_sender_pause();
        test_receiver_hold();
        test_random_track();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        drain_results();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bearings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
